/* design/hop_limited_reach_counter_core_defines.svh */
// Assertion helpers used by the core RTL.
`ifndef HOP_LIMITED_REACH_COUNTER_CORE_DEFINES_SVH
`define HOP_LIMITED_REACH_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HLRC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HLRC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/hlrc_pkg.sv */
`timescale 1ns / 1ps

package hlrc_pkg;

   localparam int NODES_DEFAULT = 64;

   localparam int NODE_W  = 6;
   localparam int HOP_W   = 8;
   localparam int COUNT_W = 7;
   localparam int CMD_W   = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

endpackage

/* design/hop_limited_reach_counter_core.sv */
// Clear: one adjacency row zeroed per cycle. Add edge: read row a, write row a while
//   reading row b, then write row b. Query: walks L levels, L <= min(hop_limit, NODES);
//   each level scans every row through the single adjacency read port, and the final
//   count tests one node per cycle. One item in flight; the result register lets the
//   next item be taken while a result waits.
// Reset: synchronous; starts a clearing sweep of every adjacency memory row with
//   req_stall high.
`timescale 1ns / 1ps
`include "hop_limited_reach_counter_core_defines.svh"

module hop_limited_reach_counter_core #(
   parameter int NODES = hlrc_pkg::NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hlrc_pkg::CMD_W-1:0]        req_command,
   input  logic [hlrc_pkg::NODE_W-1:0]       req_node_a,
   input  logic [hlrc_pkg::NODE_W-1:0]       req_node_b,
   input  logic [hlrc_pkg::HOP_W-1:0]        req_hop_limit,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hlrc_pkg::COUNT_W-1:0]      rsp_unreachable_count
);

   localparam int ADDR_W = $clog2(NODES);
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NODES - 1);
   localparam logic [NODES-1:0] ONE = NODES'(1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_ADD_A  = 4'd2;
   localparam logic [3:0] S_ADD_B  = 4'd3;
   localparam logic [3:0] S_ADD_W  = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_DRAIN  = 4'd6;
   localparam logic [3:0] S_UPDATE = 4'd7;
   localparam logic [3:0] S_COUNT  = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   logic [3:0]                        state_ff, state_in;
   logic [ADDR_W-1:0]                 idx_ff, idx_in;
   logic [hlrc_pkg::HOP_W-1:0]        level_ff, level_in;
   logic [hlrc_pkg::HOP_W-1:0]        hop_ff, hop_in;
   logic [hlrc_pkg::NODE_W-1:0]       na_ff, na_in;
   logic [hlrc_pkg::NODE_W-1:0]       nb_ff, nb_in;
   logic [NODES-1:0]                  present_ff, present_in;
   logic [NODES-1:0]                  visited_ff, visited_in;
   logic [NODES-1:0]                  frontier_ff, frontier_in;
   logic [NODES-1:0]                  next_ff, next_in;
   logic                              pend_ff, pend_in;
   logic                              pend_sel_ff, pend_sel_in;
   logic [hlrc_pkg::COUNT_W-1:0]      cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [hlrc_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [NODES-1:0]                  adj_mem [0:NODES-1];
   logic [NODES-1:0]                  rd_data_ff;
   logic [ADDR_W-1:0]                 rd_addr;
   logic [ADDR_W-1:0]                 wr_addr;
   logic [NODES-1:0]                  wr_data;
   logic                              wr_en;

   logic [NODES-1:0]                  fresh;
   logic                              src_ok;
   logic                              edge_ok;

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_unreachable_count = rsp_count_ff;

   assign src_ok  = (32'(req_node_a) < NODES);
   assign edge_ok = (32'(na_ff) < NODES) && (32'(nb_ff) < NODES);
   assign fresh   = next_ff & ~visited_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      level_in     = level_ff;
      hop_in       = hop_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      present_in   = present_ff;
      visited_in   = visited_ff;
      frontier_in  = frontier_ff;
      next_in      = next_ff;
      pend_in      = 1'b0;
      pend_sel_in  = 1'b0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rd_addr      = idx_ff;
      wr_addr      = idx_ff;
      wr_data      = '0;
      wr_en        = 1'b0;

      // row read issued last cycle lands now; fold it in if that node was on the frontier
      if (pend_ff && pend_sel_ff) begin
         next_in = next_ff | rd_data_ff;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               na_in  = req_node_a;
               nb_in  = req_node_b;
               hop_in = req_hop_limit;
               unique case (req_command)
                  hlrc_pkg::CMD_CLEAR: begin
                     present_in = '0;
                     idx_in     = '0;
                     state_in   = S_CLEAR;
                  end
                  hlrc_pkg::CMD_ADD: begin
                     state_in = S_ADD_A;
                  end
                  hlrc_pkg::CMD_QUERY: begin
                     visited_in  = src_ok ? (ONE << req_node_a) : '0;
                     frontier_in = src_ok ? (ONE << req_node_a) : '0;
                     level_in    = '0;
                     idx_in      = '0;
                     cnt_in      = '0;
                     next_in     = '0;
                     state_in    = (req_hop_limit == '0) ? S_COUNT : S_SCAN;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == LAST) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ADD_A: begin
            rd_addr  = ADDR_W'(na_ff);
            state_in = edge_ok ? S_ADD_B : S_IDLE;
         end
         S_ADD_B: begin
            // write row a while reading row b; a self loop sees the old row, same result
            wr_en      = 1'b1;
            wr_addr    = ADDR_W'(na_ff);
            wr_data    = rd_data_ff | (ONE << nb_ff);
            rd_addr    = ADDR_W'(nb_ff);
            present_in = present_ff | (ONE << na_ff) | (ONE << nb_ff);
            state_in   = S_ADD_W;
         end
         S_ADD_W: begin
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(nb_ff);
            wr_data  = rd_data_ff | (ONE << na_ff);
            state_in = S_IDLE;
         end
         S_SCAN: begin
            pend_in     = 1'b1;
            pend_sel_in = frontier_ff[idx_ff];
            if (idx_ff == LAST) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            visited_in  = visited_ff | fresh;
            frontier_in = fresh;
            level_in    = level_ff + 1'b1;
            next_in     = '0;
            idx_in      = '0;
            cnt_in      = '0;
            if ((fresh != '0) && ((level_ff + 1'b1) < hop_ff)) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            if (present_ff[idx_ff] && !visited_ff[idx_ff] && (cnt_ff != hlrc_pkg::COUNT_MAX)) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (idx_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         present_ff   <= '0;
         visited_ff   <= '0;
         frontier_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         present_ff   <= present_in;
         visited_ff   <= visited_in;
         frontier_ff  <= frontier_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff     <= level_in;
      hop_ff       <= hop_in;
      na_ff        <= na_in;
      nb_ff        <= nb_in;
      next_ff      <= next_in;
      pend_sel_ff  <= pend_sel_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
   end

   // adjacency rows: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= adj_mem[rd_addr];
   end

   `HLRC_ASSERT_NEXT(a_visited_grows, clock, reset, (state_ff == S_UPDATE), ((visited_ff & $past(visited_ff)) == $past(visited_ff)), "visited set lost a node at level update")
   `HLRC_ASSERT_SAME(a_frontier_in_visited, clock, reset, 1'b1, ((frontier_ff & ~visited_ff) == '0), "frontier holds an unvisited node")
   `HLRC_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), ($past(state_ff) == S_DONE), "result raised outside the done state")
   `HLRC_ASSERT_SAME(a_pend_only_scan, clock, reset, pend_ff, (state_ff == S_SCAN || state_ff == S_DRAIN), "row read pending outside the level scan")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int NODES = hlrc_pkg::NODES_DEFAULT;
   localparam int CMD_W = hlrc_pkg::CMD_W;
   localparam int NODE_W = hlrc_pkg::NODE_W;
   localparam int HOP_W = hlrc_pkg::HOP_W;
   localparam int COUNT_W = hlrc_pkg::COUNT_W;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1750;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;
   localparam int DIRECTED_ROWS = 23;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [NODE_W-1:0]  node_a;
      logic [NODE_W-1:0]  node_b;
      logic [HOP_W-1:0]   hops;
      bit                 known;
      logic [COUNT_W-1:0] count;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CMD_W-1:0] req_command;
   logic [NODE_W-1:0] req_node_a;
   logic [NODE_W-1:0] req_node_b;
   logic [HOP_W-1:0] req_hop_limit;
   logic rsp_valid;
   logic rsp_stall;
   logic [COUNT_W-1:0] rsp_unreachable_count;

   // graph mirror
   logic [NODES-1:0] adj_rows [NODES];
   logic [NODES-1:0] present_map;

   logic [COUNT_W-1:0] count_pending [$];
   logic [NODE_W-1:0] recent_nodes [$];

   int errors = 0;
   int sent_items = 0;
   int n_adds = 0, n_clears = 0, n_queries = 0, n_ignored = 0, n_results = 0;
   int deepest_walk = 0;
   int tx_idle_pct = 6;
   int rx_idle_pct = 61;
   int quiet_cycles = 0;
   bit holdoff_request = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{hlrc_pkg::CMD_QUERY, 6'd0,  6'd0,  8'd0,   1'b1, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd63, 6'd63, 8'd255, 1'b1, 7'd0},
      '{hlrc_pkg::CMD_ADD,   6'd0,  6'd63, 8'd0,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_ADD,   6'd5,  6'd5,  8'd0,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_ADD,   6'd63, 6'd0,  8'd255, 1'b0, 7'd0},
      '{CMD_UNUSED,          6'd63, 6'd63, 8'd255, 1'b0, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd0,  6'd0,  8'd0,   1'b1, 7'd2},
      '{hlrc_pkg::CMD_QUERY, 6'd0,  6'd0,  8'd1,   1'b1, 7'd1},
      '{hlrc_pkg::CMD_QUERY, 6'd5,  6'd0,  8'd255, 1'b1, 7'd2},
      '{hlrc_pkg::CMD_QUERY, 6'd10, 6'd0,  8'd3,   1'b1, 7'd3},
      '{hlrc_pkg::CMD_ADD,   6'd63, 6'd1,  8'd0,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_ADD,   6'd1,  6'd2,  8'd0,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_ADD,   6'd2,  6'd42, 8'd0,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd0,  6'd0,  8'd2,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd0,  6'd0,  8'd255, 1'b0, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd42, 6'd0,  8'd1,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_CLEAR, 6'd63, 6'd63, 8'd255, 1'b0, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd0,  6'd0,  8'd255, 1'b1, 7'd0},
      '{hlrc_pkg::CMD_ADD,   6'd62, 6'd62, 8'd0,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd62, 6'd21, 8'd0,   1'b1, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd0,  6'd0,  8'd0,   1'b1, 7'd1},
      '{hlrc_pkg::CMD_CLEAR, 6'd0,  6'd0,  8'd0,   1'b0, 7'd0},
      '{hlrc_pkg::CMD_QUERY, 6'd63, 6'd0,  8'd255, 1'b1, 7'd0}
   };

   hop_limited_reach_counter_core #(.NODES(NODES)) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_node_a            (req_node_a),
      .req_node_b            (req_node_b),
      .req_hop_limit         (req_hop_limit),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_unreachable_count (rsp_unreachable_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one command to the graph mirror; queries yield the unreachable count.
   task automatic reach_model_step(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] a,
                                   input logic [NODE_W-1:0] b, input logic [HOP_W-1:0] hops,
                                   output bit has_count, output logic [COUNT_W-1:0] count);
      logic [NODES-1:0] visited;
      logic [NODES-1:0] frontier;
      logic [NODES-1:0] reached_next;
      int levels;
      int ones;
      has_count = 1'b0;
      count = '0;
      case (cmd)
         hlrc_pkg::CMD_CLEAR: begin
            for (int n = 0; n < NODES; n++)
               adj_rows[n] = '0;
            present_map = '0;
         end
         hlrc_pkg::CMD_ADD: begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
            present_map[a] = 1'b1;
            present_map[b] = 1'b1;
         end
         hlrc_pkg::CMD_QUERY: begin
            visited = '0;
            visited[a] = 1'b1;
            frontier = visited;
            levels = 0;
            for (int lvl = 0; lvl < int'(hops); lvl++) begin
               reached_next = '0;
               for (int n = 0; n < NODES; n++)
                  if (frontier[n])
                     reached_next |= adj_rows[n];
               reached_next &= ~visited;
               visited |= reached_next;
               frontier = reached_next;
               levels++;
               if (reached_next == '0)
                  break;
            end
            if (levels > deepest_walk)
               deepest_walk = levels;
            ones = $countones(present_map & ~visited);
            count = (ones > int'(hlrc_pkg::COUNT_MAX)) ? hlrc_pkg::COUNT_MAX : COUNT_W'(ones);
            has_count = 1'b1;
         end
         default: ;
      endcase
   endtask

   // Drives one item and waits for its transfer; may then idle the request side.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] b, input logic [HOP_W-1:0] hops,
                            input bit known, input logic [COUNT_W-1:0] known_count);
      bit has_count;
      logic [COUNT_W-1:0] predicted;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_node_a <= a;
      req_node_b <= b;
      req_hop_limit <= hops;
      do @(posedge clock); while (req_stall);
      reach_model_step(cmd, a, b, hops, has_count, predicted);
      if (has_count)
         count_pending = {count_pending, known ? known_count : predicted};
      case (cmd)
         hlrc_pkg::CMD_CLEAR: n_clears++;
         hlrc_pkg::CMD_ADD: n_adds++;
         hlrc_pkg::CMD_QUERY: n_queries++;
         default: n_ignored++;
      endcase
      sent_items++;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 19) == 0)
         send_item(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom), HOP_W'($urandom),
                   1'b0, '0);
   endtask

   task automatic send_random_query();
      logic [NODE_W-1:0] src;
      logic [HOP_W-1:0] hops;
      int pick;
      if (recent_nodes.size() > 0 && $urandom_range(0, 3) != 0)
         src = recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
      else
         src = NODE_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6)
         hops = HOP_W'($urandom_range(0, 4));
      else if (pick < 8)
         hops = HOP_W'($urandom);
      else
         hops = '1;
      maybe_noise();
      send_item(hlrc_pkg::CMD_QUERY, src, NODE_W'($urandom), hops, 1'b0, '0);
   endtask

   task automatic send_edge(input int u, input int v);
      maybe_noise();
      if ($urandom_range(0, 1) == 1)
         send_item(hlrc_pkg::CMD_ADD, NODE_W'(v), NODE_W'(u), HOP_W'($urandom), 1'b0, '0);
      else
         send_item(hlrc_pkg::CMD_ADD, NODE_W'(u), NODE_W'(v), HOP_W'($urandom), 1'b0, '0);
      recent_nodes = {recent_nodes, NODE_W'(u)};
      recent_nodes = {recent_nodes, NODE_W'(v)};
   endtask

   // Clear (usually), build a path, a random graph or no edges, then query it.
   task automatic random_sequence();
      int kind;
      int len;
      int start;
      int stride;
      int window;
      int base;
      if ($urandom_range(0, 5) != 0) begin
         send_item(hlrc_pkg::CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                   HOP_W'($urandom), 1'b0, '0);
         recent_nodes.delete();
      end
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, NODES - 1)
                                           : $urandom_range(1, 8);
         start = $urandom_range(0, NODES - 1);
         stride = 2 * $urandom_range(0, NODES / 2 - 1) + 1;
         for (int i = 0; i < len; i++)
            send_edge((start + i * stride) % NODES, (start + (i + 1) * stride) % NODES);
      end else if (kind < 9) begin
         len = $urandom_range(1, 24);
         window = $urandom_range(4, NODES);
         base = $urandom_range(0, NODES - 1);
         for (int i = 0; i < len; i++)
            send_edge((base + $urandom_range(0, window - 1)) % NODES,
                      (base + $urandom_range(0, window - 1)) % NODES);
      end
      // kind 9: no edges this time, queries only
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
         send_random_query();
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (count_pending.size() != 0);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request) begin
            holdoff_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      logic [COUNT_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (count_pending.size() == 0) begin
            $error("unexpected result transfer, rsp_unreachable_count=%0d",
                   rsp_unreachable_count);
            errors++;
         end else begin
            want = count_pending.pop_front();
            if (rsp_unreachable_count !== want) begin
               $error("rsp_unreachable_count: expected %0d, actual %0d", want,
                      rsp_unreachable_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no transfer for %0d cycles", QUIET_LIMIT);
         $display("hop_limited_reach_counter_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int first_random;
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = hlrc_pkg::CMD_CLEAR;
      req_node_a = '0;
      req_node_b = '0;
      req_hop_limit = '0;
      for (int n = 0; n < NODES; n++)
         adj_rows[n] = '0;
      present_map = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].node_a, directed_rows[i].node_b,
                   directed_rows[i].hops, directed_rows[i].known, directed_rows[i].count);

      first_random = sent_items;
      phase = 0;
      while (sent_items - first_random < RANDOM_ITEMS) begin
         if (phase == 0 && sent_items - first_random >= RANDOM_ITEMS / 3) begin
            phase = 1;
            wait_for_results();
            tx_idle_pct = 61;
            rx_idle_pct = 6;
         end else if (phase == 1 && sent_items - first_random >= 2 * RANDOM_ITEMS / 3) begin
            phase = 2;
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            // results back up behind the long receiver hold-off
            holdoff_request = 1'b1;
            repeat (5) send_random_query();
         end
         random_sequence();
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (count_pending.size() != 0) begin
         $error("%0d results never arrived", count_pending.size());
         errors++;
      end
      $display("Covered %0d edge adds, %0d clears, %0d queries, %0d unused codes",
               n_adds, n_clears, n_queries, n_ignored);
      $display("%0d counts checked, deepest search %0d levels, %0d errors",
               n_results, deepest_walk, errors);
      if (errors == 0)
         $display("hop_limited_reach_counter_core verification clean");
      else
         $display("hop_limited_reach_counter_core verification failed");
      $finish;
   end

endmodule
